// File: sv/mlsp_pkg.sv
`timescale 1ns / 1ps

package mlsp_pkg;

  // List geometry
  localparam int LIST_DEPTH = 256;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // Field widths
  localparam int MOVE_W  = 16;
  localparam int SCORE_W = 11;
  localparam int PIECE_W = 3;
  localparam int CAP_W   = 7;
  localparam int MODE_W  = 2;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Score bonuses
  localparam logic [SCORE_W-1:0] HINT_BONUS  = SCORE_W'(1000);
  localparam logic [SCORE_W-1:0] PROMO_BONUS = SCORE_W'(100);

  // Scoring modes
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PAIR   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCORING_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HINT_MOVE    = 2'd1;

  // Number of attacker rows in the pair table
  localparam logic [PIECE_W-1:0] ATTACKER_ROWS = 3'd6;

  // Capture tables, indexed by victim (and attacker)
  localparam logic [CAP_W-1:0] VICTIM_VAL [8] = '{
    7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd90, 7'd0, 7'd0
  };

  localparam logic [CAP_W-1:0] PAIR_VAL [6][8] = '{
    '{7'd15, 7'd25, 7'd35, 7'd45, 7'd55, 7'd95, 7'd0, 7'd0},
    '{7'd14, 7'd24, 7'd34, 7'd44, 7'd54, 7'd94, 7'd0, 7'd0},
    '{7'd13, 7'd23, 7'd33, 7'd43, 7'd53, 7'd93, 7'd0, 7'd0},
    '{7'd12, 7'd22, 7'd32, 7'd42, 7'd52, 7'd92, 7'd0, 7'd0},
    '{7'd11, 7'd21, 7'd31, 7'd41, 7'd51, 7'd91, 7'd0, 7'd0},
    '{7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd90, 7'd0, 7'd0}
  };

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_PICK  = 2'd2
  } kind_t;

  // One list entry
  typedef struct packed {
    logic [MOVE_W-1:0]  move;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // Requests from the top level to the scan unit
  typedef struct packed {
    logic             load_en;
    logic [IDX_W-1:0] load_addr;
    entry_t           load_entry;
    logic             pick_start;
    logic [IDX_W-1:0] pick_idx;
    logic [CNT_W-1:0] pick_count;
  } sel_req_t;

  // Status from the scan unit
  typedef struct packed {
    logic   busy;
    logic   done;
    entry_t best;
  } sel_rsp_t;

  // Scan sequencer states
  typedef enum logic [1:0] {
    SEL_IDLE,
    SEL_FETCH,
    SEL_SCAN,
    SEL_WB
  } sel_state_t;

endpackage

// File: sv/mlsp_score.sv
`timescale 1ns / 1ps

module mlsp_score (
  input  logic [mlsp_pkg::MODE_W-1:0]  mode,
  input  logic [mlsp_pkg::MOVE_W-1:0]  hint_move,
  input  logic [mlsp_pkg::MOVE_W-1:0]  move_code,
  input  logic [mlsp_pkg::PIECE_W-1:0] attacker_piece,
  input  logic [mlsp_pkg::PIECE_W-1:0] victim_piece,
  input  logic                         queen_promotion,
  output logic [mlsp_pkg::SCORE_W-1:0] score
);
  import mlsp_pkg::*;

  logic [CAP_W-1:0] cap;

  // Capture part from the selected table
  always_comb begin
    cap = '0;
    if (mode == MODE_VICTIM) begin
      cap = VICTIM_VAL[victim_piece];
    end else if (mode == MODE_PAIR) begin
      if (attacker_piece < ATTACKER_ROWS) begin
        cap = PAIR_VAL[attacker_piece][victim_piece];
      end
    end
  end

  // Hint bonus wins over promotion bonus
  always_comb begin
    if (move_code == hint_move) begin
      score = SCORE_W'(cap) + HINT_BONUS;
    end else if (queen_promotion) begin
      score = SCORE_W'(cap) + PROMO_BONUS;
    end else begin
      score = SCORE_W'(cap);
    end
  end

endmodule

// File: sv/mlsp_sel.sv
`timescale 1ns / 1ps

module mlsp_sel (
  input  logic               clk,
  input  logic               rst_n,
  input  mlsp_pkg::sel_req_t req,
  output mlsp_pkg::sel_rsp_t rsp
);
  import mlsp_pkg::*;

  sel_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  entry_t           best_r, best_nxt;
  entry_t           rdata_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic             done;

  entry_t mem [LIST_DEPTH];

  // List storage: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    cnt_r     <= cnt_nxt;
    rd_idx_r  <= rd_idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    best_r    <= best_nxt;
  end

  // Scan: read one entry per cycle, compare against the running best, swap
  always_comb begin
    state_nxt   = state_r;
    base_nxt    = base_r;
    cnt_nxt     = cnt_r;
    rd_idx_nxt  = rd_idx_r;
    chk_idx_nxt = chk_idx_r;
    best_nxt    = best_r;
    wr_en       = 1'b0;
    wr_addr     = req.load_addr;
    wr_data     = req.load_entry;
    rd_addr     = rd_idx_r[IDX_W-1:0];
    done        = 1'b0;

    unique case (state_r)
      SEL_IDLE: begin
        if (req.load_en) begin
          wr_en = 1'b1;
        end
        if (req.pick_start) begin
          rd_addr    = req.pick_idx;
          base_nxt   = req.pick_idx;
          cnt_nxt    = req.pick_count;
          rd_idx_nxt = CNT_W'(req.pick_idx) + CNT_W'(1);
          state_nxt  = SEL_FETCH;
        end
      end
      SEL_FETCH, SEL_SCAN: begin
        if (state_r == SEL_FETCH) begin
          best_nxt = rdata_r;
        end else if (rdata_r.score > best_r.score) begin
          // later entry beats the head: swap them
          wr_en    = 1'b1;
          wr_addr  = chk_idx_r;
          wr_data  = best_r;
          best_nxt = rdata_r;
        end
        if (rd_idx_r < cnt_r) begin
          chk_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          state_nxt   = SEL_SCAN;
        end else begin
          state_nxt = SEL_WB;
        end
      end
      SEL_WB: begin
        wr_en     = 1'b1;
        wr_addr   = base_r;
        wr_data   = best_r;
        done      = 1'b1;
        state_nxt = SEL_IDLE;
      end
      default: begin
        state_nxt = SEL_IDLE;
      end
    endcase
  end

  assign rsp = '{busy: (state_r != SEL_IDLE), done: done, best: best_r};

endmodule

// File: sv/move_list_score_and_pick.sv
`timescale 1ns / 1ps

// Move list that scores moves on load and hands them back best first. Send
// beats on the in_ channel with in_tuser as kind (clear, load, pick); a clear
// or a load gives no result, and a load into a full list of LIST_DEPTH moves
// is dropped. A pick runs a selection pass over the entries from the next
// unpicked one to the end of the list through a single compare unit and a
// one-port-read list memory, and in_tready is low while the pass runs. Each
// pick returns one beat with out_tuser (found) set, or found clear and zero
// data when the list is used up. A new beat is taken only once the previous
// result has gone or is leaving. Write scoring_mode and hint_move through the
// cfg_ port while no item is in flight.
module move_list_score_and_pick (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [mlsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlsp_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,  // move_code, attacker_piece,
                                                     // victim_piece, queen_promotion
  input  logic [1:0]                      in_tuser,  // kind
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata, // best_move, best_score
  output logic                            out_tuser  // found
);
  import mlsp_pkg::*;

  localparam int OUT_PAD = 32 - MOVE_W - SCORE_W;

  logic [MODE_W-1:0]  mode_r;
  logic [MOVE_W-1:0]  hint_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   next_r, next_nxt;
  logic               out_valid_r, out_valid_nxt;
  entry_t             out_best_r, out_best_nxt;
  logic               out_found_r, out_found_nxt;

  logic               in_acc;
  logic [MOVE_W-1:0]  in_move;
  logic [PIECE_W-1:0] in_attacker;
  logic [PIECE_W-1:0] in_victim;
  logic               in_promo;
  logic [SCORE_W-1:0] load_score;
  logic               exhausted;
  sel_req_t           req;
  sel_rsp_t           rsp;

  // Input beat fields
  assign in_move     = in_tdata[15:0];
  assign in_attacker = in_tdata[18:16];
  assign in_victim   = in_tdata[21:19];
  assign in_promo    = in_tdata[22];

  assign in_tready = !rsp.busy && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign exhausted = (next_r >= count_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PAIR;
      hint_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCORING_MODE: mode_r <= cfg_data[MODE_W-1:0];
        REG_HINT_MOVE:    hint_r <= cfg_data[MOVE_W-1:0];
        default:          ;
      endcase
    end
  end

  mlsp_score u_score (
    .mode            (mode_r),
    .hint_move       (hint_r),
    .move_code       (in_move),
    .attacker_piece  (in_attacker),
    .victim_piece    (in_victim),
    .queen_promotion (in_promo),
    .score           (load_score)
  );

  mlsp_sel u_sel (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Item decode, list counters and result register
  always_comb begin
    count_nxt      = count_r;
    next_nxt       = next_r;
    out_valid_nxt  = out_valid_r;
    out_best_nxt   = out_best_r;
    out_found_nxt  = out_found_r;
    req.load_en    = 1'b0;
    req.load_addr  = count_r[IDX_W-1:0];
    req.load_entry = '{move: in_move, score: load_score};
    req.pick_start = 1'b0;
    req.pick_idx   = next_r[IDX_W-1:0];
    req.pick_count = count_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      unique case (in_tuser)
        KIND_CLEAR: begin
          count_nxt = '0;
          next_nxt  = '0;
        end
        KIND_LOAD: begin
          if (count_r < CNT_W'(LIST_DEPTH)) begin
            req.load_en = 1'b1;
            count_nxt   = count_r + CNT_W'(1);
          end
        end
        KIND_PICK: begin
          if (exhausted) begin
            out_valid_nxt = 1'b1;
            out_best_nxt  = '0;
            out_found_nxt = 1'b0;
          end else begin
            req.pick_start = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (rsp.done) begin
      out_valid_nxt = 1'b1;
      out_best_nxt  = rsp.best;
      out_found_nxt = 1'b1;
      next_nxt      = next_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      next_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      next_r      <= next_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_best_r  <= out_best_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_best_r.score, out_best_r.move};
  assign out_tuser  = out_found_r;

  // Picked position never runs past the end of the list
  a_next_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    next_r <= count_r)
    else $error("next index beyond list count");

  // List never grows past its depth
  a_count_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LIST_DEPTH))
    else $error("list count beyond depth");

  // A finished scan always finds the result register free
  a_done_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> !out_valid_r)
    else $error("scan finished while a result was pending");

  // An exhausted-list result carries zero data
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_tdata == '0))
    else $error("not-found result with nonzero data");

endmodule
